// ----- rtl/dpd_pkg.sv -----
package dpd_pkg;

  localparam int SqrtSteps = 33;
  localparam int DivSteps  = 32;
  localparam int UnitBits  = 17;

  typedef enum logic [2:0] {
    REG_CUTOFF  = 3'd0,
    REG_MIN     = 3'd1,
    REG_GAIN    = 3'd2,
    REG_GAMMA   = 3'd3,
    REG_SIGMA   = 3'd4,
    REG_INVSQRT = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [30:0] rc;
    logic [30:0] dmin;
    logic [30:0] a;
    logic [30:0] g;
    logic [30:0] s;
    logic [30:0] k;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pix, piy, pjx, pjy;
    logic signed [31:0] vix, viy, vjx, vjy;
    logic signed [31:0] noise;
  } raw_t;

  typedef struct packed {
    logic signed [33:0] dx, dy;
    logic signed [32:0] dvx, dvy;
    logic signed [31:0] noise;
  } pair_t;

  typedef struct packed {
    pair_t       p;
    logic [32:0] sep;
  } ranged_t;

  typedef struct packed {
    pair_t       p;
    logic        close;
    logic [16:0] qx, qy;
    logic        wovf;
    logic [31:0] qw;
  } quot_t;

  typedef struct packed {
    logic signed [31:0] fx, fy;
    logic               close;
  } res_t;

  // Q16.16 rescale: shift right 16 toward zero, saturate to 32 bits
  function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [47:0] m;
    logic signed [31:0] r;
    mag = p[63] ? 64'(-p) : 64'(p);
    m   = mag[63:16];
    if (p[63]) begin
      if (m > 48'h8000_0000) r = 32'sh8000_0000;
      else r = 32'(-m[31:0]);
    end else begin
      if (m > 48'h7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else r = m[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [63:0] p;
    p = 64'(x) * 64'(y);
    return qsat(p);
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/dpd_sqrt.sv -----
module dpd_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dpd_pkg::raw_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dpd_pkg::ranged_t  out_data
);
  import dpd_pkg::*;

  localparam int N = SqrtSteps + 3;

  typedef struct packed {
    pair_t       p;
    logic [32:0] mx, my;
    logic [64:0] sqx, sqy;
    logic [65:0] rad;
    logic [36:0] rem;
    logic [32:0] root;
  } sq_t;

  logic [N-1:0] v;
  logic [N:0]   adv;
  sq_t          d  [N];
  sq_t          nd [N];

  assign adv[N] = out_ready;
  for (genvar k = 0; k < N; k++) begin : g_adv
    assign adv[k] = !v[k] || adv[k+1];
  end
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (adv[k]) v[k] <= (k == 0) ? in_valid : v[k-1];
      end
    end
  end

  always_comb begin
    nd[0]       = '0;
    nd[0].p.dx  = 34'(in_data.pix) - 34'(in_data.pjx);
    nd[0].p.dy  = 34'(in_data.piy) - 34'(in_data.pjy);
    nd[0].p.dvx = 33'(in_data.vix) - 33'(in_data.vjx);
    nd[0].p.dvy = 33'(in_data.viy) - 33'(in_data.vjy);
    nd[0].p.noise = in_data.noise;
    nd[0].mx = nd[0].p.dx[33] ? 33'(-nd[0].p.dx) : nd[0].p.dx[32:0];
    nd[0].my = nd[0].p.dy[33] ? 33'(-nd[0].p.dy) : nd[0].p.dy[32:0];
  end

  always_comb begin
    nd[1]     = d[0];
    nd[1].sqx = 65'(66'(d[0].mx) * 66'(d[0].mx));
    nd[1].sqy = 65'(66'(d[0].my) * 66'(d[0].my));
  end

  always_comb begin
    nd[2]      = d[1];
    nd[2].rad  = 66'(d[1].sqx) + 66'(d[1].sqy);
    nd[2].rem  = '0;
    nd[2].root = '0;
  end

  // one root bit per stage, two radicand bits consumed from the top
  for (genvar k = 3; k < N; k++) begin : g_step
    logic [36:0] rem2;
    logic [36:0] trial;
    always_comb begin
      rem2  = {d[k-1].rem[34:0], d[k-1].rad[65:64]};
      trial = {2'b00, d[k-1].root, 2'b01};
      nd[k] = d[k-1];
      nd[k].rad = {d[k-1].rad[63:0], 2'b00};
      if (rem2 >= trial) begin
        nd[k].rem  = rem2 - trial;
        nd[k].root = {d[k-1].root[31:0], 1'b1};
      end else begin
        nd[k].rem  = rem2;
        nd[k].root = {d[k-1].root[31:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (adv[k]) d[k] <= nd[k];
    end
  end

  assign out_valid    = v[N-1];
  assign out_data.p   = d[N-1].p;
  assign out_data.sep = d[N-1].root;

endmodule

// ----- rtl/dpd_div.sv -----
module dpd_div (
  input  logic              clk,
  input  logic              rst,
  input  dpd_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  dpd_pkg::ranged_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dpd_pkg::quot_t    out_data
);
  import dpd_pkg::*;

  localparam int N = DivSteps + 1;

  typedef struct packed {
    pair_t       p;
    logic        close;
    logic [32:0] sep;
    logic [49:0] rx, ry;
    logic [16:0] qx, qy;
    logic [62:0] rw;
    logic [31:0] qw;
    logic        wovf;
  } dv_t;

  logic [N-1:0] v;
  logic [N:0]   adv;
  dv_t          d  [N];
  dv_t          nd [N];
  logic [30:0]  rc;

  assign rc = (cfg.rc == '0) ? 31'd1 : cfg.rc;

  assign adv[N] = out_ready;
  for (genvar k = 0; k < N; k++) begin : g_adv
    assign adv[k] = !v[k] || adv[k+1];
  end
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (adv[k]) v[k] <= (k == 0) ? in_valid : v[k-1];
      end
    end
  end

  always_comb begin
    logic [32:0] mx, my;
    mx = in_data.p.dx[33] ? 33'(-in_data.p.dx) : in_data.p.dx[32:0];
    my = in_data.p.dy[33] ? 33'(-in_data.p.dy) : in_data.p.dy[32:0];
    nd[0]       = '0;
    nd[0].p     = in_data.p;
    nd[0].sep   = in_data.sep;
    nd[0].close = (in_data.sep == '0) || (in_data.sep < 33'(cfg.dmin));
    nd[0].rx    = 50'({mx, 16'b0});
    nd[0].ry    = 50'({my, 16'b0});
    nd[0].rw    = 63'({in_data.sep, 16'b0});
    // quotient would not fit 32 bits: w saturates low
    nd[0].wovf  = 63'({in_data.sep, 16'b0}) >= {rc, 32'b0};
  end

  // restoring division, one quotient bit per stage; unit vector bits
  // start once the bit weight reaches 2^16
  for (genvar k = 1; k < N; k++) begin : g_step
    localparam int B = DivSteps - k;
    logic [62:0] dw;
    logic [49:0] dd;
    always_comb begin
      dw = 63'(rc) << B;
      dd = 50'(d[k-1].sep) << B;
      nd[k] = d[k-1];
      if (d[k-1].rw >= dw) begin
        nd[k].rw   = d[k-1].rw - dw;
        nd[k].qw[B] = 1'b1;
      end
      if (B < UnitBits) begin
        if (d[k-1].rx >= dd) begin
          nd[k].rx = d[k-1].rx - dd;
          nd[k].qx[B % UnitBits] = 1'b1;
        end
        if (d[k-1].ry >= dd) begin
          nd[k].ry = d[k-1].ry - dd;
          nd[k].qy[B % UnitBits] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (adv[k]) d[k] <= nd[k];
    end
  end

  assign out_valid      = v[N-1];
  assign out_data.p     = d[N-1].p;
  assign out_data.close = d[N-1].close;
  assign out_data.qx    = d[N-1].qx;
  assign out_data.qy    = d[N-1].qy;
  assign out_data.wovf  = d[N-1].wovf;
  assign out_data.qw    = d[N-1].qw;

endmodule

// ----- rtl/dpd_force.sv -----
module dpd_force (
  input  logic            clk,
  input  logic            rst,
  input  dpd_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  dpd_pkg::quot_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dpd_pkg::res_t   out_data
);
  import dpd_pkg::*;

  localparam int N = 6;

  typedef struct packed {
    logic               close;
    logic signed [31:0] ex, ey;
    logic signed [32:0] dvx, dvy;
    logic signed [31:0] noise;
    logic signed [31:0] w, w2, tc, sw, gw2, swn, dot, td, tn, s, fx, fy;
    logic signed [63:0] px, py;
  } fs_t;

  logic [N-1:0] v;
  logic [N:0]   adv;
  fs_t          d  [N];
  fs_t          nd [N];
  logic signed [31:0] ca, cg, cs, ck;

  assign ca = {1'b0, cfg.a};
  assign cg = {1'b0, cfg.g};
  assign cs = {1'b0, cfg.s};
  assign ck = {1'b0, cfg.k};

  assign adv[N] = out_ready;
  for (genvar k = 0; k < N; k++) begin : g_adv
    assign adv[k] = !v[k] || adv[k+1];
  end
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (adv[k]) v[k] <= (k == 0) ? in_valid : v[k-1];
      end
    end
  end

  always_comb begin
    logic signed [33:0] wd;
    wd = 34'sd65536 - $signed({2'b00, in_data.qw});
    nd[0]       = '0;
    nd[0].close = in_data.close;
    nd[0].dvx   = in_data.p.dvx;
    nd[0].dvy   = in_data.p.dvy;
    nd[0].noise = in_data.p.noise;
    nd[0].ex    = in_data.p.dx[33] ? -$signed(32'(in_data.qx)) : $signed(32'(in_data.qx));
    nd[0].ey    = in_data.p.dy[33] ? -$signed(32'(in_data.qy)) : $signed(32'(in_data.qy));
    nd[0].w     = in_data.wovf ? 32'sh8000_0000 : sat34(wd);
  end

  always_comb begin
    nd[1]    = d[0];
    nd[1].w2 = qmul(d[0].w, d[0].w);
    nd[1].tc = qmul(ca, d[0].w);
    nd[1].sw = qmul(cs, d[0].w);
    nd[1].px = 64'(d[0].dvx) * 64'(d[0].ex);
    nd[1].py = 64'(d[0].dvy) * 64'(d[0].ey);
  end

  always_comb begin
    nd[2]     = d[1];
    nd[2].gw2 = qmul(cg, d[1].w2);
    nd[2].swn = qmul(d[1].sw, d[1].noise);
    nd[2].dot = qsat(d[1].px + d[1].py);
  end

  always_comb begin
    nd[3]    = d[2];
    nd[3].td = qmul(d[2].gw2, d[2].dot);
    nd[3].tn = qmul(d[2].swn, ck);
  end

  always_comb begin
    nd[4]   = d[3];
    nd[4].s = sat34(34'(d[3].tc) - 34'(d[3].td) + 34'(d[3].tn));
  end

  always_comb begin
    nd[5]    = d[4];
    nd[5].fx = d[4].close ? '0 : qmul(d[4].s, d[4].ex);
    nd[5].fy = d[4].close ? '0 : qmul(d[4].s, d[4].ey);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (adv[k]) d[k] <= nd[k];
    end
  end

  assign out_valid      = v[N-1];
  assign out_data.fx    = d[N-1].fx;
  assign out_data.fy    = d[N-1].fy;
  assign out_data.close = d[N-1].close;

endmodule

// ----- rtl/dpd_pair_force.sv -----
// Channel   Signals                          Moves
// input     in_valid / in_ready             one pair: positions, velocities, noise
// output    out_valid / out_ready           force_x, force_y, too_close
// config    wr_en / wr_index / wr_data      one register write per cycle, no wait
//
// One pair enters per cycle unless the output stalls. There are 3
// difference and square stages, 33 square-root stages, 33 divider stages
// and 6 multiply stages. A stage holds its item while the next one holds,
// so bubbles collapse; an output stall holds all full stages up to a bubble.
// rst is synchronous; it empties the pipeline and loads register defaults.
module dpd_pair_force (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [30:0]        wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_i_x,
  input  logic signed [31:0] pos_i_y,
  input  logic signed [31:0] pos_j_x,
  input  logic signed [31:0] pos_j_y,
  input  logic signed [31:0] vel_i_x,
  input  logic signed [31:0] vel_i_y,
  input  logic signed [31:0] vel_j_x,
  input  logic signed [31:0] vel_j_y,
  input  logic signed [31:0] noise_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic               too_close
);
  import dpd_pkg::*;

  cfg_t    cfg;
  raw_t    raw;
  ranged_t rng;
  quot_t   quo;
  res_t    res;
  logic    rng_valid, rng_ready, quo_valid, quo_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rc   <= 31'd65536;
      cfg.dmin <= 31'd66;
      cfg.a    <= 31'd1638400;
      cfg.g    <= 31'd294912;
      cfg.s    <= 31'd196608;
      cfg.k    <= 31'd655360;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_CUTOFF:  cfg.rc   <= wr_data;
        REG_MIN:     cfg.dmin <= wr_data;
        REG_GAIN:    cfg.a    <= wr_data;
        REG_GAMMA:   cfg.g    <= wr_data;
        REG_SIGMA:   cfg.s    <= wr_data;
        REG_INVSQRT: cfg.k    <= wr_data;
        default: ;
      endcase
    end
  end

  assign raw = '{pix: pos_i_x, piy: pos_i_y, pjx: pos_j_x, pjy: pos_j_y,
                 vix: vel_i_x, viy: vel_i_y, vjx: vel_j_x, vjy: vel_j_y,
                 noise: noise_sample};

  dpd_sqrt u_sqrt (
    .clk, .rst,
    .in_valid, .in_ready, .in_data(raw),
    .out_valid(rng_valid), .out_ready(rng_ready), .out_data(rng)
  );

  dpd_div u_div (
    .clk, .rst, .cfg,
    .in_valid(rng_valid), .in_ready(rng_ready), .in_data(rng),
    .out_valid(quo_valid), .out_ready(quo_ready), .out_data(quo)
  );

  dpd_force u_force (
    .clk, .rst, .cfg,
    .in_valid(quo_valid), .in_ready(quo_ready), .in_data(quo),
    .out_valid, .out_ready, .out_data(res)
  );

  assign force_x   = res.fx;
  assign force_y   = res.fy;
  assign too_close = res.close;

  a_close_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && too_close) |-> (force_x == 0 && force_y == 0))
    else $error("too_close result with nonzero force");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output stage");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input blocked without output stall");

endmodule

// ----- bench/tb.sv -----
module tb;
  import dpd_pkg::*;

  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;
  localparam int Latency = 75;

  typedef struct {
    raw_t p;
    bit   typed;
    res_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [2:0] wr_index;
  logic [30:0] wr_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] pos_i_x, pos_i_y, pos_j_x, pos_j_y;
  logic signed [31:0] vel_i_x, vel_i_y, vel_j_x, vel_j_y, noise_sample;
  logic signed [31:0] force_x, force_y;
  logic too_close;

  cfg_t cfg;
  res_t force_q[$];
  row_t rows[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  dpd_pair_force u_dut (.*);

  always #4 clk = ~clk;

  function automatic longint shr_sat(longint v);
    longint m;
    m = (v < 0 ? -v : v) >>> 16;
    if (v < 0) return (m > 64'sd2147483648) ? -64'sd2147483648 : -m;
    return (m > 64'sd2147483647) ? 64'sd2147483647 : m;
  endfunction

  function automatic longint fix_mul(longint x, longint y);
    return shr_sat(x * y);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [65:0] n);
    logic [67:0] rem, trial;
    logic [63:0] root;
    rem = '0;
    root = '0;
    for (int k = 32; k >= 0; k--) begin
      rem = (rem << 2) | 68'((n >> (2 * k)) & 66'd3);
      trial = 68'((root << 2) | 64'd1);
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic res_t pair_force(raw_t r, cfg_t c);
    longint dx, dy, dvx, dvy, ex, ey, w, w2, dot, tc, td, tn, s, rc;
    logic [63:0] mx, my, sep;
    logic [65:0] ax, ay;
    res_t o;
    dx = longint'(r.pix) - longint'(r.pjx);
    dy = longint'(r.piy) - longint'(r.pjy);
    dvx = longint'(r.vix) - longint'(r.vjx);
    dvy = longint'(r.viy) - longint'(r.vjy);
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    ax = mx;
    ay = my;
    sep = floor_sqrt(ax * ax + ay * ay);
    if (sep == 0 || sep < 64'(c.dmin)) begin
      o.fx = '0;
      o.fy = '0;
      o.close = 1'b1;
      return o;
    end
    ex = longint'((mx << 16) / sep);
    ey = longint'((my << 16) / sep);
    if (dx < 0) ex = -ex;
    if (dy < 0) ey = -ey;
    rc = (c.rc == 0) ? 64'sd1 : longint'(c.rc);
    w = clamp32(64'sd65536 - longint'((sep << 16) / 64'(rc)));
    w2 = fix_mul(w, w);
    dot = shr_sat(dvx * ex + dvy * ey);
    tc = fix_mul(longint'(c.a), w);
    td = fix_mul(fix_mul(longint'(c.g), w2), dot);
    tn = fix_mul(fix_mul(fix_mul(longint'(c.s), w), longint'(r.noise)), longint'(c.k));
    s = clamp32(tc - td + tn);
    o.fx = 32'(fix_mul(s, ex));
    o.fy = 32'(fix_mul(s, ey));
    o.close = 1'b0;
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // long receiver hold-off, counted down in cycles
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output side: check each transfer, then decide the next ready
  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (force_q.size() == 0) begin
          report_mismatch("result with nothing pending");
        end else begin
          e = force_q.pop_front();
          if (force_x !== e.fx)
            report_mismatch($sformatf("force_x %h, want %h", force_x, e.fx));
          if (force_y !== e.fy)
            report_mismatch($sformatf("force_y %h, want %h", force_y, e.fy));
          if (too_close !== e.close)
            report_mismatch($sformatf("too_close %b, want %b", too_close, e.close));
        end
      end
      if (hold_req || hold_left > 1) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [30:0] v);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= v;
    case (idx)
      REG_CUTOFF:  cfg.rc = v;
      REG_MIN:     cfg.dmin = v;
      REG_GAIN:    cfg.a = v;
      REG_GAMMA:   cfg.g = v;
      REG_SIGMA:   cfg.s = v;
      REG_INVSQRT: cfg.k = v;
      default: ;
    endcase
  endtask

  task automatic load_all(cfg_t c);
    write_reg(REG_CUTOFF, c.rc);
    write_reg(REG_MIN, c.dmin);
    write_reg(REG_GAIN, c.a);
    write_reg(REG_GAMMA, c.g);
    write_reg(REG_SIGMA, c.s);
    write_reg(REG_INVSQRT, c.k);
    write_reg(REG_SPARE6, 31'($urandom));
    write_reg(REG_SPARE7, 31'($urandom));
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // valid stays up across back-to-back transfers; it drops only for a gap
  task automatic send_pair(raw_t p, bit typed, res_t r);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    {pos_i_x, pos_i_y, pos_j_x, pos_j_y} <= {p.pix, p.piy, p.pjx, p.pjy};
    {vel_i_x, vel_i_y, vel_j_x, vel_j_y} <= {p.vix, p.viy, p.vjx, p.vjy};
    noise_sample <= p.noise;
    do @(posedge clk); while (!in_ready);
    force_q.push_back(typed ? r : pair_force(p, cfg));
  endtask

  function automatic logic signed [31:0] scaled(int lo);
    logic signed [31:0] v;
    v = $urandom >> $urandom_range(lo, 31);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic raw_t random_pair();
    raw_t p;
    if ($urandom_range(0, 9) == 0) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    end else begin
      p.pix = $urandom;
      p.piy = $urandom;
      p.pjx = p.pix - scaled(6);
      p.pjy = p.piy - scaled(6);
      p.vix = scaled(0);
      p.viy = scaled(0);
      p.vjx = scaled(0);
      p.vjy = scaled(0);
      p.noise = scaled(8);
    end
    return p;
  endfunction

  function automatic logic [30:0] rand_reg();
    case ($urandom_range(0, 3))
      0: return 31'h7FFF_FFFF;
      1: return 31'($urandom);
      default: return 31'($urandom >> $urandom_range(4, 16));
    endcase
  endfunction

  initial begin
    localparam logic signed [31:0] MX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MN = 32'sh8000_0000;
    cfg_t c;
    res_t none;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    in_valid = 1'b0;
    {pos_i_x, pos_i_y, pos_j_x, pos_j_y} = '0;
    {vel_i_x, vel_i_y, vel_j_x, vel_j_y} = '0;
    noise_sample = '0;
    none = '{fx: '0, fy: '0, close: 1'b0};
    cfg = '{rc: 31'd65536, dmin: 31'd66, a: 31'd1638400, g: 31'd294912,
            s: 31'd196608, k: 31'd655360};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // default registers; typed rows are coincident, under the floor, or at w = 0
    rows.push_back('{'{0, 0, 0, 0, 5, 6, 7, 8, 9}, 1'b1, '{0, 0, 1'b1}});
    rows.push_back('{'{65, 0, 0, 0, MX, MN, 0, 0, MX}, 1'b1, '{0, 0, 1'b1}});
    rows.push_back('{'{-1, -1, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 1'b1}});
    rows.push_back('{'{65536, 0, 0, 0, 1000, 0, -2000, 0, 65536}, 1'b1, '{0, 0, 1'b0}});
    rows.push_back('{'{66, 0, 0, 0, 300, 0, 0, 0, 0}, 1'b0, none});
    rows.push_back('{'{MX, 0, MN, 0, 0, 0, 0, 0, 0}, 1'b0, none});
    rows.push_back('{'{MN, MN, MX, MX, MX, MX, MN, MN, MN}, 1'b0, none});
    rows.push_back('{'{32768, 0, 0, 0, MX, 0, MN, 0, 0}, 1'b0, none});
    rows.push_back('{'{0, 32768, 0, 0, 0, MN, 0, MX, 0}, 1'b0, none});
    rows.push_back('{'{1000, 0, 0, 0, 0, 0, 0, 0, MX}, 1'b0, none});
    rows.push_back('{'{0, -1000, 0, 0, 0, 0, 0, 0, MN}, 1'b0, none});
    rows.push_back('{'{-20000, 30000, 0, 0, 4096, -8192, 700, 100, 65536}, 1'b0, none});
    rows.push_back('{'{MX, MX, MX, MX, 1, 1, 1, 1, 1}, 1'b1, '{0, 0, 1'b1}});
    foreach (rows[i]) send_pair(rows[i].p, rows[i].typed, rows[i].r);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        in_valid <= 1'b0;
        while (force_q.size() != 0) @(posedge clk);
        c = '{rc: rand_reg(), dmin: 31'($urandom >> $urandom_range(12, 31)),
              a: rand_reg(), g: rand_reg(), s: rand_reg(), k: rand_reg()};
        case (ph)
          1: begin c.rc = '0; c.dmin = '0; end
          2: begin c.rc = 31'h7FFF_FFFF; c.dmin = 31'h7FFF_FFFF; end
          3: {c.a, c.g, c.s, c.k} = {4{31'h7FFF_FFFF}};
          4: {c.a, c.g, c.s, c.k} = '0;
          default: ;
        endcase
        load_all(c);
      end
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 84; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 84; end
        default: begin send_idle = 23; recv_stall = 23; end
      endcase
      // long hold-off at the output so the pipeline fills and backs up
      if (ph == 4) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      repeat (92) send_pair(random_pair(), 1'b0, none);
    end

    in_valid <= 1'b0;
    while (force_q.size() != 0) @(posedge clk);
    repeat (Latency + 25) @(posedge clk);
    if (errors == 0) begin
      $display("dpd_pair_force regression: pass");
    end else begin
      $display("dpd_pair_force regression: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("dpd_pair_force regression: fail");
    $finish;
  end

endmodule
